@@ sv/vfr_pkg.sv @@
// ----------------------------------------------------------------------------
// vfr_pkg
// shared types, codes and defaults of the value frequency ranker
// ----------------------------------------------------------------------------
`default_nettype none
package vfr_pkg;
   localparam int LIST_DEPTH_DEF = 1024;
   localparam int MAP_SIZE_DEF   = 256;

   localparam logic [1:0] ACT_ADD     = 2'd0;
   localparam logic [1:0] ACT_REBUILD = 2'd1;
   localparam logic [1:0] ACT_FETCH   = 2'd2;
   localparam logic [1:0] ACT_RESTART = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic        from_ranking;
   } rsp_type;
endpackage
`default_nettype wire

@@ sv/vfr_front.sv @@
// ----------------------------------------------------------------------------
// vfr_front
// accepts transactions into a two-entry queue ahead of the execution engine
// ----------------------------------------------------------------------------
`default_nettype none
module vfr_front import vfr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         q_avail,
   output req_type      q_item,
   input  wire logic    q_pop
);
   req_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign busy    = (cnt_ff == 2'd2);
   assign push    = start && !busy;
   assign q_avail = (cnt_ff != 2'd0);
   assign q_item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_avail);
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop && q_avail);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= req_item;
      end
   end
endmodule
`default_nettype wire

@@ sv/vfr_back.sv @@
// ----------------------------------------------------------------------------
// vfr_back
// executes queued transactions: ring store, histogram and counting-sort ranking
// ----------------------------------------------------------------------------
`default_nettype none
module vfr_back import vfr_pkg::*; #(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF,
   parameter int MAP_SIZE   = MAP_SIZE_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_avail,
   input  wire req_type q_item,
   output logic         q_pop,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);
   localparam int AW  = $clog2(LIST_DEPTH);
   localparam int CW  = $clog2(LIST_DEPTH + 1);
   localparam int VW  = $clog2(MAP_SIZE);
   localparam int SW  = $clog2(MAP_SIZE + 1);
   localparam int MX  = (LIST_DEPTH > MAP_SIZE) ? LIST_DEPTH : MAP_SIZE;
   localparam int IW  = $clog2(MX + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_FETCH = 4'd1;
   localparam logic [3:0] S_HCLR = 4'd2;
   localparam logic [3:0] S_CRD = 4'd3;
   localparam logic [3:0] S_CHR = 4'd4;
   localparam logic [3:0] S_CWR = 4'd5;
   localparam logic [3:0] S_SCLR = 4'd6;
   localparam logic [3:0] S_NRD = 4'd7;
   localparam logic [3:0] S_NSR = 4'd8;
   localparam logic [3:0] S_NWR = 4'd9;
   localparam logic [3:0] S_PRD = 4'd10;
   localparam logic [3:0] S_PWR = 4'd11;
   localparam logic [3:0] S_ARD = 4'd12;
   localparam logic [3:0] S_ASR = 4'd13;
   localparam logic [3:0] S_AWR = 4'd14;

   logic [31:0]   ring_mem [LIST_DEPTH];
   logic [CW-1:0] hist_mem [MAP_SIZE];
   logic [SW-1:0] slot_mem [LIST_DEPTH + 1];
   logic [VW-1:0] rank_mem [MAP_SIZE];

   logic [31:0]   ring_rd_ff;
   logic [CW-1:0] hist_rd_ff;
   logic [SW-1:0] slot_rd_ff;
   logic [VW-1:0] rank_rd_ff;

   logic [3:0]    state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in, idx_inc, idx_dec;
   logic [AW-1:0] wp_ff, wp_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          valid_ff, valid_in;
   logic [31:0]   cursor_ff, cursor_in;
   logic [SW-1:0] pos_ff, pos_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [VW-1:0] haddr_ff, haddr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          ring_we;
   logic [AW-1:0] ring_ra;
   logic          hist_we;
   logic [VW-1:0] hist_wa, hist_ra;
   logic [CW-1:0] hist_wd;
   logic          slot_we;
   logic [CW-1:0] slot_wa, slot_ra;
   logic [SW-1:0] slot_wd;
   logic          rank_we;
   logic [VW-1:0] rank_ra;
   logic          ring_last, idx_map_last;

   assign idx_inc      = idx_ff + IW'(1);
   assign idx_dec      = idx_ff - IW'(1);
   assign ring_last    = (idx_inc == IW'(fill_ff));
   assign idx_map_last = (idx_ff == IW'(MAP_SIZE - 1));
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_item     = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      valid_in     = valid_ff;
      cursor_in    = cursor_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      haddr_in     = haddr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      q_pop        = 1'b0;
      ring_we      = 1'b0;
      ring_ra      = idx_ff[AW-1:0];
      hist_we      = 1'b0;
      hist_wa      = idx_ff[VW-1:0];
      hist_wd      = '0;
      hist_ra      = idx_ff[VW-1:0];
      slot_we      = 1'b0;
      slot_wa      = idx_ff[CW-1:0];
      slot_wd      = '0;
      slot_ra      = idx_ff[CW-1:0];
      rank_we      = 1'b0;
      rank_ra      = cursor_ff[VW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (q_avail) begin
               q_pop = 1'b1;
               unique case (q_item.action)
                  ACT_ADD: begin
                     ring_we      = 1'b1;
                     wp_in        = (wp_ff == AW'(LIST_DEPTH - 1)) ? '0 : wp_ff + AW'(1);
                     if (fill_ff != CW'(LIST_DEPTH)) begin
                        fill_in = fill_ff + CW'(1);
                     end
                     rsp_valid_in = 1'b1;
                  end
                  ACT_REBUILD: begin
                     idx_in   = '0;
                     state_in = S_HCLR;
                  end
                  ACT_FETCH: begin
                     if (cursor_ff != 32'hFFFF_FFFF) begin
                        cursor_in = cursor_ff + 32'd1;
                     end
                     if (valid_ff && cursor_ff < 32'(MAP_SIZE)) begin
                        state_in = S_FETCH;
                     end else begin
                        rsp_valid_in        = 1'b1;
                        rsp_in.result_value = cursor_ff;
                     end
                  end
                  ACT_RESTART: begin
                     cursor_in    = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_FETCH: begin
            rsp_valid_in        = 1'b1;
            rsp_in.result_value = 32'(rank_rd_ff);
            rsp_in.from_ranking = 1'b1;
            state_in            = S_IDLE;
         end
         S_HCLR: begin
            hist_we = 1'b1;
            idx_in  = idx_inc;
            if (idx_map_last) begin
               idx_in   = '0;
               state_in = (fill_ff == '0) ? S_SCLR : S_CRD;
            end
         end
         S_CRD: begin
            state_in = S_CHR;
         end
         S_CHR: begin
            if (ring_rd_ff < 32'(MAP_SIZE)) begin
               hist_ra  = ring_rd_ff[VW-1:0];
               haddr_in = ring_rd_ff[VW-1:0];
               state_in = S_CWR;
            end else if (ring_last) begin
               idx_in   = '0;
               state_in = S_SCLR;
            end else begin
               idx_in   = idx_inc;
               state_in = S_CRD;
            end
         end
         S_CWR: begin
            hist_we = 1'b1;
            hist_wa = haddr_ff;
            hist_wd = hist_rd_ff + CW'(1);
            if (ring_last) begin
               idx_in   = '0;
               state_in = S_SCLR;
            end else begin
               idx_in   = idx_inc;
               state_in = S_CRD;
            end
         end
         S_SCLR: begin
            slot_we = 1'b1;
            idx_in  = idx_inc;
            if (idx_ff == IW'(LIST_DEPTH)) begin
               idx_in   = '0;
               state_in = S_NRD;
            end
         end
         S_NRD: begin
            state_in = S_NSR;
         end
         S_NSR: begin
            slot_ra  = hist_rd_ff;
            cnt_in   = hist_rd_ff;
            state_in = S_NWR;
         end
         S_NWR: begin
            slot_we  = 1'b1;
            slot_wa  = cnt_ff;
            slot_wd  = slot_rd_ff + SW'(1);
            idx_in   = idx_inc;
            state_in = S_NRD;
            if (idx_map_last) begin
               idx_in   = IW'(LIST_DEPTH);
               pos_in   = '0;
               state_in = S_PRD;
            end
         end
         S_PRD: begin
            state_in = S_PWR;
         end
         S_PWR: begin
            slot_we  = 1'b1;
            slot_wd  = pos_ff;
            pos_in   = pos_ff + slot_rd_ff;
            idx_in   = idx_dec;
            state_in = S_PRD;
            if (idx_ff == '0) begin
               idx_in   = IW'(MAP_SIZE - 1);
               state_in = S_ARD;
            end
         end
         S_ARD: begin
            state_in = S_ASR;
         end
         S_ASR: begin
            slot_ra  = hist_rd_ff;
            cnt_in   = hist_rd_ff;
            state_in = S_AWR;
         end
         S_AWR: begin
            slot_we  = 1'b1;
            slot_wa  = cnt_ff;
            slot_wd  = slot_rd_ff + SW'(1);
            rank_we  = 1'b1;
            idx_in   = idx_dec;
            state_in = S_ARD;
            if (idx_ff == '0) begin
               valid_in     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         valid_ff     <= 1'b0;
         cursor_ff    <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         valid_ff     <= valid_in;
         cursor_ff    <= cursor_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      haddr_ff <= haddr_in;
      rsp_ff   <= rsp_in;
   end

   // memories
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wp_ff] <= q_item.value;
      end
      ring_rd_ff <= ring_mem[ring_ra];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
      hist_rd_ff <= hist_mem[hist_ra];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      slot_rd_ff <= slot_mem[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem[slot_rd_ff[VW-1:0]] <= idx_ff[VW-1:0];
      end
      rank_rd_ff <= rank_mem[rank_ra];
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(LIST_DEPTH))
      else $error("fill count beyond store depth");

   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= AW'(LIST_DEPTH - 1))
      else $error("write pointer beyond store depth");

   a_valid_sticky: assert property (@(posedge clock) disable iff (reset)
      valid_ff |=> valid_ff)
      else $error("ranking valid dropped");

   a_fetch_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FETCH |=> rsp_valid_ff && rsp_ff.from_ranking)
      else $error("ranked fetch gave no ranked transaction");
endmodule
`default_nettype wire

@@ sv/value_frequency_ranker_core.sv @@
// ----------------------------------------------------------------------------
// value_frequency_ranker_core
// ring of recent values ranked by frequency with a fetch cursor
// ----------------------------------------------------------------------------
// path: queue, then response register; ranked fetch adds the rank memory read
// throughput: one transaction a cycle, except during a ranked fetch or rebuild
// rebuild: clear and fill histogram, clear slots, then count, prefix, rank
// sequential memory read-modify-write passes set the rebuild length
// input stalls once the two-entry queue fills; the receiver cannot stall
// reset: synchronous; clears pointers, fill count, cursor and ranking valid
`default_nettype none
module value_frequency_ranker_core import vfr_pkg::*; #(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF,
   parameter int MAP_SIZE   = MAP_SIZE_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);
   logic    q_avail;
   logic    q_pop;
   req_type q_item;

   vfr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .q_avail  (q_avail),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   vfr_back #(
      .LIST_DEPTH (LIST_DEPTH),
      .MAP_SIZE   (MAP_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_avail   (q_avail),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );
endmodule
`default_nettype wire

@@ tb/sv/value_frequency_ranker_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// value_frequency_ranker_core_tb
// self-checking bench: add, rebuild, fetch and restart traffic against a
// behavioural copy of the ring, histogram ranking and fetch cursor
// ----------------------------------------------------------------------------
`default_nettype none

class rank_scoreboard;
   localparam int DEPTH = vfr_pkg::LIST_DEPTH_DEF;
   localparam int MAP   = vfr_pkg::MAP_SIZE_DEF;

   logic [31:0] ring [DEPTH];
   int unsigned wr_ptr;
   int unsigned filled;
   logic [7:0]  ranking [MAP];
   bit          ranked;
   logic [31:0] cursor;
   vfr_pkg::rsp_type pending [$];
   int unsigned errors;

   function new();
      wr_ptr = 0;
      filled = 0;
      ranked = 0;
      cursor = 0;
      errors = 0;
   endfunction

   function void rebuild();
      int unsigned counts [MAP];
      int unsigned pos;
      for (int i = 0; i < MAP; i++) counts[i] = 0;
      for (int i = 0; i < filled; i++)
         if (ring[i] < MAP) counts[ring[i]]++;
      pos = 0;
      for (int c = DEPTH; c >= 0; c--)
         for (int v = MAP - 1; v >= 0; v--)
            if (counts[v] == c) begin
               ranking[pos] = v[7:0];
               pos++;
            end
      ranked = 1;
   endfunction

   function void note_request(vfr_pkg::req_type rq);
      vfr_pkg::rsp_type rs;
      rs = '0;
      case (rq.action)
         vfr_pkg::ACT_ADD: begin
            ring[wr_ptr] = rq.value;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            if (filled < DEPTH) filled++;
         end
         vfr_pkg::ACT_REBUILD: rebuild();
         vfr_pkg::ACT_FETCH: begin
            if (ranked && cursor < MAP) begin
               rs.result_value = {24'd0, ranking[cursor]};
               rs.from_ranking = 1'b1;
            end else begin
               rs.result_value = cursor;
            end
            if (cursor != 32'hFFFF_FFFF) cursor++;
         end
         default: cursor = 0;
      endcase
      pending = {pending, rs};
   endfunction

   function void check_response(vfr_pkg::rsp_type got);
      vfr_pkg::rsp_type want;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected transaction: %h / %b",
                                    got.result_value, got.from_ranking);
         return;
      end
      want = pending.pop_front();
      if (got.result_value !== want.result_value || got.from_ranking !== want.from_ranking) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: expected %h / %b, actual %h / %b", want.result_value,
                     want.from_ranking, got.result_value, got.from_ranking);
      end
   endfunction
endclass

module value_frequency_ranker_core_tb;
   import vfr_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   rank_scoreboard board = new();
   int unsigned cycles = 0;
   int unsigned send_idle = 21;

   value_frequency_ranker_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid) board.check_response(rsp_item);

   task automatic send(logic [1:0] act, logic [31:0] val);
      while ($urandom_range(99) < send_idle) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_item <= '{action: act, value: val};
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request('{action: act, value: val});
   endtask

   task automatic drain();
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return $urandom();
         1: return 32'hFFFF_FFFF;
         2: return 256 + $urandom_range(3);
         default: return $urandom_range(15);
      endcase
   endfunction

   task automatic random_items(int n);
      int r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 45) send(ACT_ADD, pick_value());
         else if (r < 47) send(ACT_REBUILD, $urandom());
         else if (r < 92) send(ACT_FETCH, $urandom());
         else send(ACT_RESTART, $urandom());
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // fetch before any rebuild, empty-ring rebuild
      send(ACT_FETCH, 32'hFFFF_FFFF);
      send(ACT_REBUILD, 0);
      send(ACT_FETCH, 0);
      send(ACT_FETCH, 0);
      send(ACT_ADD, 32'd0);
      send(ACT_ADD, 32'd255);
      send(ACT_ADD, 32'd256);
      send(ACT_ADD, 32'hFFFF_FFFF);
      send(ACT_ADD, 32'hAAAA_AAAA);
      send(ACT_ADD, 32'h5555_5555);
      send(ACT_ADD, 32'd255);
      send(ACT_RESTART, 0);
      send(ACT_REBUILD, 0);
      send(ACT_FETCH, 0);
      send(ACT_FETCH, 0);
      send(ACT_FETCH, 0);
      drain();
      // fill the ring past wrap, walk the cursor off the table
      for (int k = 0; k < 1100; k++) send(ACT_ADD, $urandom_range(7));
      send(ACT_REBUILD, 0);
      for (int k = 0; k < 260; k++) send(ACT_FETCH, 0);
      send(ACT_RESTART, 0);
      drain();
      random_items(110);
      send_idle = 57;
      random_items(110);
      drain();
      send_idle = 0;
      random_items(100);
      drain();
      if (board.errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire

@@ sim.f @@
sv/vfr_pkg.sv
sv/vfr_front.sv
sv/vfr_back.sv
sv/value_frequency_ranker_core.sv
tb/sv/value_frequency_ranker_core_tb.sv
